// ----- src/tps_pkg.sv -----
package tps_pkg;

    localparam int MAX_LANDMARKS = 64;

    localparam int LM_AW    = $clog2(MAX_LANDMARKS);
    localparam int LM_CNT_W = $clog2(MAX_LANDMARKS + 1);

    localparam int OP_W     = 2;
    localparam int SLOT_W   = 6;
    localparam int COORD_W  = 24;
    localparam int TERM_W   = 32;
    localparam int CNT_W    = 7;
    localparam int AFF_ROWS = 4;

    localparam int D_W     = COORD_W + 1;
    localparam int SQ1_W   = 2 * D_W - 1;
    localparam int SQ_W    = SQ1_W + 1;
    localparam int NSTEP   = SQ_W / 2;
    localparam int R_W     = SQ_W + 1;
    localparam int RT_W    = NSTEP;
    localparam int MA_W    = RT_W + 1;
    localparam int PROD_W  = MA_W + TERM_W;
    localparam int FRAC_W  = 16;
    localparam int ACC_W   = PROD_W - FRAC_W + $clog2(MAX_LANDMARKS + AFF_ROWS) + 1;

    localparam int COORD_MAX = 8388607;
    localparam int COORD_MIN = -8388608;

    localparam logic [OP_W-1:0] OP_LOAD_LM  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_AFF = 2'd1;
    localparam logic [OP_W-1:0] OP_WARP     = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AFFINE,
        S_STREAM,
        S_DRAIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic             start;
        logic             lm_wr;
        logic             aff_wr;
        logic             aff_v;
        logic [1:0]       aff_row;
        logic             rd_v;
        logic [LM_AW-1:0] rd_addr;
        logic             out_load;
    } cmd_t;

    typedef struct packed {
        logic busy;
    } sts_t;

endpackage

// ----- src/tps_in_if.sv -----
interface tps_in_if;
    import tps_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic signed [TERM_W-1:0]  qx;
    logic signed [TERM_W-1:0]  qy;
    logic signed [TERM_W-1:0]  qz;

    modport source (output valid, op, slot, px, py, pz, qx, qy, qz, input ready);
    modport sink (input valid, op, slot, px, py, pz, qx, qy, qz, output ready);
endinterface

// ----- src/tps_out_if.sv -----
interface tps_out_if;
    import tps_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] wx;
    logic signed [COORD_W-1:0] wy;
    logic signed [COORD_W-1:0] wz;
    logic                      clipped;

    modport source (output valid, wx, wy, wz, clipped, input ready);
    modport sink (input valid, wx, wy, wz, clipped, output ready);
endinterface

// ----- src/tps_ram.sv -----
module tps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- src/tps_ctrl.sv -----
module tps_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [tps_pkg::OP_W-1:0]  in_op,
    input  logic [tps_pkg::SLOT_W-1:0] in_slot,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    input  logic                      cfg_we,
    input  logic [tps_pkg::CNT_W-1:0] cfg_wdata,
    output tps_pkg::cmd_t             cmd,
    input  tps_pkg::sts_t             sts
);
    import tps_pkg::*;

    state_t              state_reg, state_next;
    logic [LM_CNT_W-1:0] cnt_reg, cnt_next;
    logic [LM_CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0]    count_reg;
    logic                out_valid_reg, out_valid_next;
    logic [LM_CNT_W-1:0] n_clamped;

    assign n_clamped = (32'(count_reg) > MAX_LANDMARKS) ? LM_CNT_W'(MAX_LANDMARKS)
                                                         : LM_CNT_W'(count_reg);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            n_reg         <= '0;
            count_reg     <= CNT_W'(64);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_op == OP_WARP)
                begin
                    state_next = S_AFFINE;
                    cnt_next   = '0;
                    n_next     = n_clamped;
                end
            end
            S_AFFINE:
            begin
                cnt_next = cnt_reg + LM_CNT_W'(1);
                if (cnt_reg == LM_CNT_W'(AFF_ROWS - 2))
                begin
                    cnt_next   = '0;
                    state_next = (n_reg == '0) ? S_DRAIN : S_STREAM;
                end
            end
            S_STREAM:
            begin
                cnt_next = cnt_reg + LM_CNT_W'(1);
                if (cnt_reg == n_reg - LM_CNT_W'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!sts.busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_op)
                        OP_LOAD_LM:  cmd.lm_wr  = 32'(in_slot) < MAX_LANDMARKS;
                        OP_LOAD_AFF: cmd.aff_wr = 32'(in_slot) < AFF_ROWS;
                        OP_WARP:     cmd.start  = 1'b1;
                        default:     cmd.start  = 1'b0;
                    endcase
                end
            end
            S_AFFINE:
            begin
                cmd.aff_v   = 1'b1;
                cmd.aff_row = cnt_reg[1:0];
            end
            S_STREAM:
            begin
                cmd.rd_v    = 1'b1;
                cmd.rd_addr = cnt_reg[LM_AW-1:0];
            end
            S_DONE:
            begin
                cmd.out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a waiting result");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.rd_v && cmd.aff_v))
        else $error("affine step and landmark read in one cycle");
    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_v |-> (cnt_reg < n_reg))
        else $error("landmark read beyond active count");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == S_AFFINE && cnt_reg == '0))
        else $error("vertex start did not enter affine phase");
endmodule

// ----- src/tps_dp.sv -----
module tps_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tps_pkg::cmd_t                      cmd,
    output tps_pkg::sts_t                      sts,
    input  logic [tps_pkg::SLOT_W-1:0]         slot,
    input  logic signed [tps_pkg::COORD_W-1:0] px,
    input  logic signed [tps_pkg::COORD_W-1:0] py,
    input  logic signed [tps_pkg::COORD_W-1:0] pz,
    input  logic signed [tps_pkg::TERM_W-1:0]  qx,
    input  logic signed [tps_pkg::TERM_W-1:0]  qy,
    input  logic signed [tps_pkg::TERM_W-1:0]  qz,
    output logic signed [tps_pkg::COORD_W-1:0] wx,
    output logic signed [tps_pkg::COORD_W-1:0] wy,
    output logic signed [tps_pkg::COORD_W-1:0] wz,
    output logic                               clipped
);
    import tps_pkg::*;

    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(COORD_MAX);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(COORD_MIN);

    logic signed [COORD_W-1:0] p_reg [3];
    logic signed [TERM_W-1:0]  aff_reg [AFF_ROWS][3];

    logic [3*COORD_W-1:0] pos_rdata;
    logic [3*TERM_W-1:0]  wt_rdata;

    logic                  rd_v_reg, s1_v_reg, s2_v_reg, s3_v_reg;
    logic signed [D_W-1:0] s1_d_reg [3];
    logic [SQ1_W-1:0]      s2_sq_reg [3];
    logic [SQ_W-1:0]       s3_sum_reg;
    logic [3*TERM_W-1:0]   s1_w_reg, s2_w_reg, s3_w_reg;

    logic [SQ_W-1:0]     sv_reg [0:NSTEP];
    logic [R_W-1:0]      sr_reg [0:NSTEP];
    logic [3*TERM_W-1:0] sw_reg [0:NSTEP];
    logic                sval_reg [0:NSTEP];

    logic signed [MA_W-1:0]    ma;
    logic signed [TERM_W-1:0]  mb [3];
    logic signed [COORD_W-1:0] p_sel;
    logic [1:0]                row_sel;
    logic signed [PROD_W-1:0]  prod_reg [3];
    logic                      prod_v_reg;
    logic signed [ACC_W-1:0]   acc_reg [3];
    logic signed [ACC_W-1:0]   sat [3];
    logic [2:0]                clip;
    logic                      pipe_busy;

    tps_ram #(.WIDTH(3 * COORD_W), .DEPTH(MAX_LANDMARKS)) u_pos_ram (
        .clk   (clk),
        .we    (cmd.lm_wr),
        .waddr (LM_AW'(slot)),
        .wdata ({pz, py, px}),
        .raddr (cmd.rd_addr),
        .rdata (pos_rdata)
    );

    tps_ram #(.WIDTH(3 * TERM_W), .DEPTH(MAX_LANDMARKS)) u_wt_ram (
        .clk   (clk),
        .we    (cmd.lm_wr),
        .waddr (LM_AW'(slot)),
        .wdata ({qz, qy, qx}),
        .raddr (cmd.rd_addr),
        .rdata (wt_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            p_reg[0] <= px;
            p_reg[1] <= py;
            p_reg[2] <= pz;
        end
        if (cmd.aff_wr)
        begin
            aff_reg[slot[1:0]][0] <= qx;
            aff_reg[slot[1:0]][1] <= qy;
            aff_reg[slot[1:0]][2] <= qz;
        end
    end

    // Front of the landmark stream: difference, squares, sum of squares.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= cmd.rd_v;
            s1_v_reg <= rd_v_reg;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [2*D_W-1:0] sq_full;
        for (int c = 0; c < 3; c++)
        begin
            s1_d_reg[c] <= D_W'(p_reg[c]) - D_W'($signed(pos_rdata[c*COORD_W +: COORD_W]));
            sq_full = s1_d_reg[c] * s1_d_reg[c];
            s2_sq_reg[c] <= sq_full[SQ1_W-1:0];
        end
        s3_sum_reg <= SQ_W'(s2_sq_reg[0]) + SQ_W'(s2_sq_reg[1]) + SQ_W'(s2_sq_reg[2]);
        s1_w_reg   <= wt_rdata;
        s2_w_reg   <= s1_w_reg;
        s3_w_reg   <= s2_w_reg;
    end

    // Square root, one result bit per stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sval_reg[0] <= 1'b0;
        end
        else
        begin
            sval_reg[0] <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sv_reg[0] <= s3_sum_reg;
        sr_reg[0] <= '0;
        sw_reg[0] <= s3_w_reg;
    end

    for (genvar i = 0; i < NSTEP; i++)
    begin : g_sqrt
        localparam logic [R_W-1:0] BIT = R_W'(1) << (2 * (NSTEP - 1 - i));
        logic [R_W-1:0] trial;
        logic           ge;

        assign trial = sr_reg[i] + BIT;
        assign ge    = R_W'(sv_reg[i]) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sval_reg[i+1] <= 1'b0;
            end
            else
            begin
                sval_reg[i+1] <= sval_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            sv_reg[i+1] <= ge ? sv_reg[i] - trial[SQ_W-1:0] : sv_reg[i];
            sr_reg[i+1] <= ge ? (sr_reg[i] >> 1) + BIT : sr_reg[i] >> 1;
            sw_reg[i+1] <= sw_reg[i];
        end
    end

    // Shared multipliers: affine terms first, then distance times weights.
    assign row_sel = cmd.aff_row + 2'd1;
    assign p_sel   = p_reg[cmd.aff_row];

    always_comb
    begin
        if (sval_reg[NSTEP])
        begin
            ma = $signed({1'b0, sr_reg[NSTEP][RT_W-1:0]});
            for (int c = 0; c < 3; c++)
            begin
                mb[c] = $signed(sw_reg[NSTEP][c*TERM_W +: TERM_W]);
            end
        end
        else
        begin
            ma = MA_W'(p_sel);
            for (int c = 0; c < 3; c++)
            begin
                mb[c] = aff_reg[row_sel][c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= sval_reg[NSTEP] || cmd.aff_v;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod_reg[c] <= ma * mb[c];
            if (cmd.start)
            begin
                acc_reg[c] <= ACC_W'(aff_reg[0][c]);
            end
            else if (prod_v_reg)
            begin
                acc_reg[c] <= acc_reg[c] + ACC_W'(prod_reg[c] >>> FRAC_W);
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            clip[c] = 1'b1;
            if (acc_reg[c] > ACC_MAX)
            begin
                sat[c] = ACC_MAX;
            end
            else if (acc_reg[c] < ACC_MIN)
            begin
                sat[c] = ACC_MIN;
            end
            else
            begin
                sat[c]  = acc_reg[c];
                clip[c] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            wx      <= sat[0][COORD_W-1:0];
            wy      <= sat[1][COORD_W-1:0];
            wz      <= sat[2][COORD_W-1:0];
            clipped <= |clip;
        end
    end

    always_comb
    begin
        pipe_busy = rd_v_reg || s1_v_reg || s2_v_reg || s3_v_reg || prod_v_reg;
        for (int i = 0; i <= NSTEP; i++)
        begin
            pipe_busy = pipe_busy || sval_reg[i];
        end
        sts.busy = pipe_busy;
    end

    a_mult_share: assert property (@(posedge clk) disable iff (!rst_n)
        !(sval_reg[NSTEP] && cmd.aff_v))
        else $error("distance and affine step collide at the multipliers");
    a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !pipe_busy)
        else $error("result loaded while landmark terms still in flight");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !pipe_busy)
        else $error("vertex started over a busy pipeline");
endmodule

// ----- src/thin_plate_spline_point_warp_top.sv -----
// Channel   Dir  Beat                                  Handshake
// req       in   op, slot, px, py, pz, qx, qy, qz      req.valid / req.ready
// rsp       out  wx, wy, wz, clipped                   rsp.valid / rsp.ready
// cfg       in   cfg_wdata = landmark_count            cfg_we, no wait
//
// A load beat writes its table entry as it is taken. A warp beat runs three affine steps,
// then one landmark per cycle, n being the active landmark count, into a pipeline whose
// depth is set by the 25-stage square root.
// No clearing pass after reset; unwritten table entries read as garbage.
// req is taken only when no warp is in flight; a waiting result in rsp does not
// block it, and a finished warp holds until rsp has room.
module thin_plate_spline_point_warp_top (
    input  logic                      clk,
    input  logic                      rst_n,
    tps_in_if.sink                    req,
    tps_out_if.source                 rsp,
    input  logic                      cfg_we,
    input  logic [tps_pkg::CNT_W-1:0] cfg_wdata
);
    import tps_pkg::*;

    cmd_t cmd;
    sts_t sts;

    tps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_op     (req.op),
        .in_slot   (req.slot),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

    tps_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .slot    (req.slot),
        .px      (req.px),
        .py      (req.py),
        .pz      (req.pz),
        .qx      (req.qx),
        .qy      (req.qy),
        .qz      (req.qz),
        .wx      (rsp.wx),
        .wy      (rsp.wy),
        .wz      (rsp.wz),
        .clipped (rsp.clipped)
    );
endmodule

// ----- dv/tb_thin_plate_spline_point_warp_top.sv -----
`timescale 1ns / 1ps

module tb_thin_plate_spline_point_warp_top;
    import tps_pkg::*;

    // Opcode that the block drops without a result.
    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

    typedef struct {
        logic signed [COORD_W-1:0] wx;
        logic signed [COORD_W-1:0] wy;
        logic signed [COORD_W-1:0] wz;
        logic                      clipped;
    } warp_res_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    tps_in_if  req();
    tps_out_if rsp();

    thin_plate_spline_point_warp_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow of the block's tables and register.
    logic signed [COORD_W-1:0] lm_pos [MAX_LANDMARKS][3];
    logic signed [TERM_W-1:0]  lm_wgt [MAX_LANDMARKS][3];
    logic signed [TERM_W-1:0]  aff    [AFF_ROWS][3];
    int unsigned               active_count;

    warp_res_t pending_warps[$];
    int        mismatches;
    int        rsp_idle_pct;
    bit        failed;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint floor16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void predict_beat(logic [OP_W-1:0] op, int unsigned slot,
                                         longint p[3], longint q[3]);
        longint acc[3];
        longint v;
        longint unsigned sq;
        longint d;
        longint radius;
        warp_res_t r;
        bit clip;
        int unsigned n;
        if (op == OP_LOAD_LM)
        begin
            for (int c = 0; c < 3; c++)
            begin
                lm_pos[slot][c] = p[c][COORD_W-1:0];
                lm_wgt[slot][c] = q[c][TERM_W-1:0];
            end
            return;
        end
        if (op == OP_LOAD_AFF)
        begin
            if (slot < AFF_ROWS)
                for (int c = 0; c < 3; c++)
                    aff[slot][c] = q[c][TERM_W-1:0];
            return;
        end
        if (op != OP_WARP)
            return;
        for (int c = 0; c < 3; c++)
        begin
            acc[c] = aff[0][c];
            for (int i = 0; i < 3; i++)
                acc[c] += floor16(p[i] * longint'(aff[i+1][c]));
        end
        n = (active_count > MAX_LANDMARKS) ? MAX_LANDMARKS : active_count;
        for (int k = 0; k < n; k++)
        begin
            sq = 0;
            for (int c = 0; c < 3; c++)
            begin
                d = p[c] - longint'(lm_pos[k][c]);
                sq += longint'(d * d);
            end
            radius = root_floor(sq);
            for (int c = 0; c < 3; c++)
                acc[c] += floor16(radius * longint'(lm_wgt[k][c]));
        end
        clip = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            v = acc[c];
            if (v > COORD_MAX)
            begin
                v = COORD_MAX;
                clip = 1'b1;
            end
            else if (v < COORD_MIN)
            begin
                v = COORD_MIN;
                clip = 1'b1;
            end
            acc[c] = v;
        end
        r.wx = acc[0][COORD_W-1:0];
        r.wy = acc[1][COORD_W-1:0];
        r.wz = acc[2][COORD_W-1:0];
        r.clipped = clip;
        pending_warps = {pending_warps, r};
    endfunction

    // Valid stays high after an accepted beat; the next call either drives the
    // next beat or idles, and wait_quiet drops it before any pause.
    task automatic send_beat(logic [OP_W-1:0] op, int unsigned slot,
                             longint p[3], longint q[3], int idle_pct);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.op    <= op;
        req.slot  <= slot[SLOT_W-1:0];
        req.px    <= p[0][COORD_W-1:0];
        req.py    <= p[1][COORD_W-1:0];
        req.pz    <= p[2][COORD_W-1:0];
        req.qx    <= q[0][TERM_W-1:0];
        req.qy    <= q[1][TERM_W-1:0];
        req.qz    <= q[2][TERM_W-1:0];
        do
            @(posedge clk);
        while (!req.ready);
        predict_beat(op, slot, p, q);
        @(negedge clk);
    endtask

    function automatic longint rand_coord(bit narrow);
        if (narrow)
            return longint'($urandom_range(2 * 65536 * 16, 0)) - 65536 * 16;
        return longint'(signed'($urandom()) >>> 8);
    endfunction

    function automatic longint rand_term(bit narrow);
        if (narrow)
            return longint'($urandom_range(2 * 65536 * 2, 0)) - 65536 * 2;
        return longint'(signed'($urandom()));
    endfunction

    task automatic load_landmark(int unsigned slot, bit narrow, int idle_pct);
        longint p[3];
        longint q[3];
        for (int c = 0; c < 3; c++)
        begin
            p[c] = rand_coord(narrow);
            q[c] = rand_term(narrow);
        end
        send_beat(OP_LOAD_LM, slot, p, q, idle_pct);
    endtask

    task automatic load_affine(int unsigned row, bit narrow, int idle_pct);
        longint p[3];
        longint q[3];
        for (int c = 0; c < 3; c++)
        begin
            p[c] = rand_coord(0);
            q[c] = rand_term(narrow);
        end
        send_beat(OP_LOAD_AFF, row, p, q, idle_pct);
    endtask

    task automatic warp_vertex(longint x, longint y, longint z, int idle_pct);
        longint p[3];
        longint q[3];
        p = '{x, y, z};
        for (int c = 0; c < 3; c++)
            q[c] = rand_term(0);
        send_beat(OP_WARP, $urandom_range(63, 0), p, q, idle_pct);
    endtask

    // A load beat may still be in flight when the last warp result lands.
    task automatic wait_quiet();
        req.valid <= 1'b0;
        while (pending_warps.size() != 0)
            @(negedge clk);
        repeat (MAX_LANDMARKS + 50)
            @(negedge clk);
    endtask

    task automatic set_count(int unsigned n);
        wait_quiet();
        cfg_wdata <= n[CNT_W-1:0];
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        active_count = n;
    endtask

    task automatic fill_tables(bit narrow, int idle_pct);
        for (int k = 0; k < MAX_LANDMARKS; k++)
            load_landmark(k, narrow, idle_pct);
        for (int r = 0; r < AFF_ROWS; r++)
            load_affine(r, narrow, idle_pct);
    endtask

    task automatic test_directed();
        longint p[3];
        longint q[3];
        fill_tables(1, 0);
        // Identity affine so that extreme vertices map onto themselves.
        p = '{0, 0, 0};
        q = '{0, 0, 0};
        send_beat(OP_LOAD_AFF, 0, p, q, 0);
        q = '{65536, 0, 0};
        send_beat(OP_LOAD_AFF, 1, p, q, 0);
        q = '{0, 65536, 0};
        send_beat(OP_LOAD_AFF, 2, p, q, 0);
        q = '{0, 0, 65536};
        send_beat(OP_LOAD_AFF, 3, p, q, 0);
        set_count(0);
        warp_vertex(COORD_MAX, COORD_MIN, 0, 0);
        warp_vertex(COORD_MIN, COORD_MAX, -1, 0);
        // Ignored affine rows and the reserved opcode.
        q = '{32'sh7fffffff, -32'sh80000000, 1};
        send_beat(OP_LOAD_AFF, 4, p, q, 0);
        send_beat(OP_LOAD_AFF, 63, p, q, 0);
        send_beat(OP_IGNORED, 17, p, q, 0);
        set_count(1);
        warp_vertex(0, 0, 0, 0);
        set_count(127);
        warp_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 0);
        warp_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 0);
        // Full-range weights drive the sum into saturation.
        load_landmark(0, 0, 0);
        load_affine(0, 0, 0);
        warp_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 0);
        set_count(MAX_LANDMARKS);
        warp_vertex(12345, -6789, 65536, 0);
    endtask

    task automatic test_random(int beats, int idle_pct);
        int kind;
        for (int i = 0; i < beats; i++)
        begin
            kind = $urandom_range(99, 0);
            if (kind < 40)
                warp_vertex(rand_coord($urandom_range(1, 0)), rand_coord($urandom_range(1, 0)),
                            rand_coord($urandom_range(1, 0)), idle_pct);
            else if (kind < 75)
                load_landmark($urandom_range(63, 0), $urandom_range(3, 0) != 0, idle_pct);
            else if (kind < 90)
                load_affine($urandom_range(3, 0), $urandom_range(3, 0) != 0, idle_pct);
            else
            begin
                longint p[3];
                longint q[3];
                for (int c = 0; c < 3; c++)
                begin
                    p[c] = rand_coord(0);
                    q[c] = rand_term(0);
                end
                if ($urandom_range(1, 0))
                    send_beat(OP_IGNORED, $urandom_range(63, 0), p, q, idle_pct);
                else
                    send_beat(OP_LOAD_AFF, $urandom_range(63, 4), p, q, idle_pct);
            end
        end
    endtask

    task automatic test_counts();
        int unsigned counts[6];
        counts = '{2, 17, 63, 64, 65, 5};
        foreach (counts[i])
        begin
            set_count(counts[i]);
            test_random(180, 34);
        end
    endtask

    always @(negedge clk)
        rsp.ready <= ($urandom_range(99, 0) >= rsp_idle_pct);

    always @(posedge clk)
    begin
        warp_res_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_warps.size() == 0)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h %h %h %b",
                             rsp.wx, rsp.wy, rsp.wz, rsp.clipped);
            end
            else
            begin
                e = pending_warps.pop_front();
                if (rsp.wx !== e.wx || rsp.wy !== e.wy || rsp.wz !== e.wz
                    || rsp.clipped !== e.clipped)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("warp mismatch: expected %h %h %h %b, got %h %h %h %b",
                                 e.wx, e.wy, e.wz, e.clipped,
                                 rsp.wx, rsp.wy, rsp.wz, rsp.clipped);
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        failed       = 1'b0;
        mismatches   = 0;
        active_count = MAX_LANDMARKS;
        rsp_idle_pct = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        req.valid    = 1'b0;
        req.op       = OP_LOAD_LM;
        req.slot     = '0;
        req.px       = '0;
        req.py       = '0;
        req.pz       = '0;
        req.qx       = '0;
        req.qy       = '0;
        req.qz       = '0;
        rsp.ready    = 1'b0;
        repeat (11)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        // No idling on either side for this stretch.
        test_random(100, 0);
        rsp_idle_pct = 34;
        fill_tables(0, 34);
        test_counts();
        wait_quiet();
        if (failed)
            $display("FAILURE");
        else
            $display("SUCCESS");
        $finish;
    end
endmodule
